[rtl/core/nva_pkg.sv]
// Shared types and constants for the note voice allocator.
package nva_pkg;

    localparam int NUM_INSTANCES_DEF = 16;
    localparam int MASK_W            = 16;
    localparam int CHANNEL_W         = 4;
    localparam int NOTE_W            = 7;
    localparam int STATUS_W          = 3;
    localparam int INDEX_W           = 4;
    localparam int RATING_W          = 3;
    localparam int RATE_NUM          = 6;

    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    // Instance ratings, lower wins.
    localparam logic [RATING_W-1:0] RATE_SAME_NOTE     = 3'd0;
    localparam logic [RATING_W-1:0] RATE_SAME_IDLE     = 3'd1;
    localparam logic [RATING_W-1:0] RATE_INVALID       = 3'd2;
    localparam logic [RATING_W-1:0] RATE_OTHER_IDLE    = 3'd3;
    localparam logic [RATING_W-1:0] RATE_SAME_PLAYING  = 3'd4;
    localparam logic [RATING_W-1:0] RATE_OTHER_PLAYING = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED    = 3'd0,
        ST_FRESH     = 3'd1,
        ST_STOLEN    = 3'd2,
        ST_NOPROG    = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_NOTFOUND  = 3'd5,
        ST_FOUNDNOPG = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;  // register request and per-instance ratings
        logic commit;   // update table, load result register
    } t_cmd;

endpackage

[rtl/core/nva_ctrl.sv]
// Sequencing controller: request intake, resolve step, result handshake.
module nva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nva_pkg::t_cmd o_cmd
);

    nva_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nva_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        out_free       = !r_out_valid || !i_out_stall;
        case (r_state)
            nva_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = nva_pkg::S_RESOLVE;
                end
            end
            nva_pkg::S_RESOLVE: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = nva_pkg::S_IDLE;
                end
            end
            default: n_state = nva_pkg::S_IDLE;
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    a_accept_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == nva_pkg::S_RESOLVE))
        else $error("accepted request did not enter resolve");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !(r_out_valid && i_out_stall))
        else $error("commit over a held result");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("result valid without commit");

endmodule

[rtl/core/nva_dp.sv]
// Datapath: instance table, rating compare, min select and result register.
module nva_dp #(
    parameter int NUM_INSTANCES = nva_pkg::NUM_INSTANCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nva_pkg::MASK_W-1:0]    i_cfg_wdata,
    input  nva_pkg::t_cmd                 i_cmd,
    input  logic                          i_command,
    input  logic [nva_pkg::CHANNEL_W-1:0] i_channel,
    input  logic [nva_pkg::NOTE_W-1:0]    i_note,
    output logic [nva_pkg::STATUS_W-1:0]  o_status,
    output logic [nva_pkg::INDEX_W-1:0]   o_instance_index,
    output logic [nva_pkg::RATING_W-1:0]  o_rating
);

    localparam int IDX_W = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;

    logic [nva_pkg::MASK_W-1:0] r_prog_mask;

    // instance table
    logic [NUM_INSTANCES-1:0]          r_inst_valid;
    logic [NUM_INSTANCES-1:0]          r_inst_playing;
    logic [nva_pkg::CHANNEL_W-1:0]     r_inst_channel [NUM_INSTANCES];
    logic [nva_pkg::NOTE_W-1:0]        r_inst_note    [NUM_INSTANCES];

    // request stage
    logic                                           r_command;
    logic [nva_pkg::CHANNEL_W-1:0]                  r_channel;
    logic [nva_pkg::NOTE_W-1:0]                     r_note;
    logic                                           r_has_prog;
    logic [NUM_INSTANCES-1:0][nva_pkg::RATE_NUM-1:0] r_rat, n_rat;
    logic [NUM_INSTANCES-1:0]                       r_found, n_found;

    // result register
    logic [nva_pkg::STATUS_W-1:0] r_status, n_status;
    logic [nva_pkg::INDEX_W-1:0]  r_index, n_index;
    logic [nva_pkg::RATING_W-1:0] r_rating, n_rating;

    logic [nva_pkg::RATE_NUM-1:0] any_rate;
    logic [nva_pkg::RATING_W-1:0] best;
    logic [NUM_INSTANCES-1:0]     sel;
    logic [IDX_W-1:0]             win_idx, found_idx, res_idx;
    logic                         any_found;
    logic [IDX_W+nva_pkg::INDEX_W-1:0] idx_wide;
    logic                         do_alloc, do_release;

    // one-hot rating of every instance against the incoming request
    always_comb begin
        logic same_ch;
        logic same_nt;
        for (int i = 0; i < NUM_INSTANCES; i++) begin
            same_ch    = r_inst_channel[i] == i_channel;
            same_nt    = r_inst_note[i] == i_note;
            n_rat[i]   = '0;
            n_found[i] = r_inst_valid[i] && r_inst_playing[i] && same_ch && same_nt;
            if (!r_inst_valid[i])
                n_rat[i][nva_pkg::RATE_INVALID] = 1'b1;
            else if (same_ch && same_nt)
                n_rat[i][nva_pkg::RATE_SAME_NOTE] = 1'b1;
            else if (same_ch && r_inst_playing[i])
                n_rat[i][nva_pkg::RATE_SAME_PLAYING] = 1'b1;
            else if (same_ch)
                n_rat[i][nva_pkg::RATE_SAME_IDLE] = 1'b1;
            else if (r_inst_playing[i])
                n_rat[i][nva_pkg::RATE_OTHER_PLAYING] = 1'b1;
            else
                n_rat[i][nva_pkg::RATE_OTHER_IDLE] = 1'b1;
        end
    end

    // lowest rating present, then lowest index holding it
    always_comb begin
        any_rate = '0;
        for (int r = 0; r < nva_pkg::RATE_NUM; r++)
            for (int i = 0; i < NUM_INSTANCES; i++)
                any_rate[r] = any_rate[r] | r_rat[i][r];
        best = '0;
        for (int r = nva_pkg::RATE_NUM - 1; r >= 0; r--)
            if (any_rate[r]) best = nva_pkg::RATING_W'(r);
        for (int i = 0; i < NUM_INSTANCES; i++)
            sel[i] = r_rat[i][best];
        win_idx   = '0;
        found_idx = '0;
        for (int i = NUM_INSTANCES - 1; i >= 0; i--) begin
            if (sel[i])     win_idx   = IDX_W'(i);
            if (r_found[i]) found_idx = IDX_W'(i);
        end
        any_found = |r_found;
    end

    always_comb begin
        n_status   = nva_pkg::ST_NOPROG;
        n_rating   = '0;
        res_idx    = '0;
        do_alloc   = 1'b0;
        do_release = 1'b0;
        if (r_command == nva_pkg::CMD_NOTE_ON) begin
            if (r_has_prog) begin
                do_alloc = 1'b1;
                res_idx  = win_idx;
                n_rating = best;
                if (best inside {nva_pkg::RATE_SAME_NOTE, nva_pkg::RATE_SAME_IDLE,
                                 nva_pkg::RATE_SAME_PLAYING})
                    n_status = nva_pkg::ST_REUSED;
                else if (best == nva_pkg::RATE_OTHER_PLAYING)
                    n_status = nva_pkg::ST_STOLEN;
                else
                    n_status = nva_pkg::ST_FRESH;
            end
        end else if (!any_found) begin
            n_status = nva_pkg::ST_NOTFOUND;
        end else begin
            res_idx = found_idx;
            if (r_has_prog) begin
                n_status   = nva_pkg::ST_RELEASED;
                do_release = 1'b1;
            end else begin
                n_status = nva_pkg::ST_FOUNDNOPG;
            end
        end
        idx_wide = {{nva_pkg::INDEX_W{1'b0}}, res_idx};
        n_index  = idx_wide[nva_pkg::INDEX_W-1:0];
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_mask    <= '0;
            r_inst_valid   <= '0;
            r_inst_playing <= '0;
        end else begin
            if (i_cfg_we) r_prog_mask <= i_cfg_wdata;
            if (i_cmd.commit && do_alloc) begin
                r_inst_valid[win_idx]   <= 1'b1;
                r_inst_playing[win_idx] <= 1'b1;
            end
            if (i_cmd.commit && do_release)
                r_inst_playing[found_idx] <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_alloc) begin
            r_inst_channel[win_idx] <= r_channel;
            r_inst_note[win_idx]    <= r_note;
        end
        if (i_cmd.capture) begin
            r_command  <= i_command;
            r_channel  <= i_channel;
            r_note     <= i_note;
            r_has_prog <= r_prog_mask[i_channel];
            r_rat      <= n_rat;
            r_found    <= n_found;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_index  <= n_index;
            r_rating <= n_rating;
        end
    end

    assign o_status         = r_status;
    assign o_instance_index = r_index;
    assign o_rating         = r_rating;

endmodule

[rtl/core/note_voice_allocator_core.sv]
// Top level of the note voice allocator: controller plus datapath.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-------------------------------
//  config   | in        | i_cfg_we                      | i_cfg_wdata (program mask)
//  request  | in        | i_in_valid / o_in_stall       | i_command, i_channel, i_note
//  result   | out       | o_out_valid / i_out_stall     | o_status, o_instance_index,
//           |           |                               | o_rating
//
// On accept, the request and a one-hot rating of every instance are registered;
// the resolve step then resolves the min select and priority encode, updates the
// instance table and loads the result register.
// The resolve step waits while a previous result is held by i_out_stall, so a
// new request is taken while one result still waits to be read.
// Reset (synchronous, i_rst_n low) clears the program mask, all valid and
// playing flags, the controller state and the result valid.
module note_voice_allocator_core #(
    parameter int NUM_INSTANCES = nva_pkg::NUM_INSTANCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // program mask register
    input  logic                          i_cfg_we,
    input  logic [nva_pkg::MASK_W-1:0]    i_cfg_wdata,
    // note request
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [nva_pkg::CHANNEL_W-1:0] i_channel,
    input  logic [nva_pkg::NOTE_W-1:0]    i_note,
    // allocation result
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nva_pkg::STATUS_W-1:0]  o_status,
    output logic [nva_pkg::INDEX_W-1:0]   o_instance_index,
    output logic [nva_pkg::RATING_W-1:0]  o_rating
);

    nva_pkg::t_cmd cmd;

    // handshakes and sequencing
    nva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // instance table, rating and selection
    nva_dp #(
        .NUM_INSTANCES (NUM_INSTANCES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (cmd),
        .i_command        (i_command),
        .i_channel        (i_channel),
        .i_note           (i_note),
        .o_status         (o_status),
        .o_instance_index (o_instance_index),
        .o_rating         (o_rating)
    );

endmodule

[bench/tb_note_voice_allocator_core.sv]
// Self-checking bench for note_voice_allocator_core: voice table predictor and scoreboard.
import nva_pkg::*;

typedef struct {
    t_status              status;
    logic [INDEX_W-1:0]   index;
    logic [RATING_W-1:0]  rating;
} alloc_result_t;

class voice_table_model;
    localparam int VOICES = NUM_INSTANCES_DEF;

    bit [MASK_W-1:0]    prog_mask;
    bit                 in_use[VOICES];
    bit                 sounding[VOICES];
    bit [CHANNEL_W-1:0] voice_chan[VOICES];
    bit [NOTE_W-1:0]    voice_note[VOICES];
    alloc_result_t      pending_results[$];
    int                 mismatch_count;

    function new();
        prog_mask      = '0;
        mismatch_count = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Apply one accepted request to the table and queue the result it must produce.
    function void note_request(logic cmd, logic [CHANNEL_W-1:0] ch, logic [NOTE_W-1:0] nt);
        alloc_result_t res;
        int best;
        int best_rate;
        int r;
        int hit;
        bit has_prog;
        has_prog   = prog_mask[ch];
        res.status = ST_NOTFOUND;
        res.index  = '0;
        res.rating = '0;
        if (cmd == CMD_NOTE_ON) begin
            if (!has_prog) begin
                res.status = ST_NOPROG;
            end else begin
                best      = 0;
                best_rate = RATE_NUM;
                for (int i = 0; i < VOICES; i++) begin
                    if (!in_use[i])
                        r = RATE_INVALID;
                    else if (voice_chan[i] == ch && voice_note[i] == nt)
                        r = RATE_SAME_NOTE;
                    else if (voice_chan[i] == ch)
                        r = sounding[i] ? RATE_SAME_PLAYING : RATE_SAME_IDLE;
                    else
                        r = sounding[i] ? RATE_OTHER_PLAYING : RATE_OTHER_IDLE;
                    if (r < best_rate) begin
                        best_rate = r;
                        best      = i;
                    end
                end
                if (in_use[best] && voice_chan[best] == ch)
                    res.status = ST_REUSED;
                else if (in_use[best] && sounding[best])
                    res.status = ST_STOLEN;
                else
                    res.status = ST_FRESH;
                in_use[best]     = 1'b1;
                sounding[best]   = 1'b1;
                voice_chan[best] = ch;
                voice_note[best] = nt;
                res.index        = INDEX_W'(best);
                res.rating       = RATING_W'(best_rate);
            end
        end else begin
            hit = -1;
            for (int i = 0; i < VOICES; i++) begin
                if (hit < 0 && in_use[i] && sounding[i] &&
                    voice_chan[i] == ch && voice_note[i] == nt)
                    hit = i;
            end
            if (hit >= 0) begin
                res.index = INDEX_W'(hit);
                if (has_prog) begin
                    res.status    = ST_RELEASED;
                    sounding[hit] = 1'b0;
                end else begin
                    res.status = ST_FOUNDNOPG;
                end
            end
        end
        pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                      logic [RATING_W-1:0] rt);
        alloc_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d index %0d rating %0d",
                                      st, idx, rt));
            return;
        end
        want = pending_results.pop_front();
        if (st !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        if (idx !== want.index)
            report_mismatch($sformatf("index %0d, want %0d", idx, want.index));
        if (rt !== want.rating)
            report_mismatch($sformatf("rating %0d, want %0d", rt, want.rating));
    endtask
endclass

module tb_note_voice_allocator_core;

    localparam int VOICES      = NUM_INSTANCES_DEF;
    // cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [MASK_W-1:0]     i_cfg_wdata      = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic                  i_command        = CMD_NOTE_ON;
    logic [CHANNEL_W-1:0]  i_channel        = '0;
    logic [NOTE_W-1:0]     i_note           = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [INDEX_W-1:0]    o_instance_index;
    logic [RATING_W-1:0]   o_rating;

    voice_table_model      voices;
    int                    send_idle_pct = 0;   // chance per cycle the sender holds off
    int                    stall_pct     = 0;   // chance per cycle the receiver stalls
    int                    quiet_cycles  = 0;
    logic [CHANNEL_W-1:0]  chan_pool[4];
    logic [NOTE_W-1:0]     note_pool[6];

    note_voice_allocator_core #(
        .NUM_INSTANCES(VOICES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_channel       (i_channel),
        .i_note          (i_note),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_instance_index(o_instance_index),
        .o_rating        (o_rating)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor and hang watchdog. Everything here samples the values
    // that were stable before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0)
                voices.check_result(o_status, o_instance_index, o_rating);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted. Valid is only lowered
    // when a gap is inserted, so back-to-back requests keep it high.
    task automatic send_request(input logic cmd, input logic [CHANNEL_W-1:0] ch,
                                input logic [NOTE_W-1:0] nt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_channel  <= ch;
        i_note     <= nt;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        voices.note_request(cmd, ch, nt);
    endtask

    // Mask writes happen only with the block drained; every request yields a
    // result, so an empty queue plus a short pause means idle.
    task automatic write_program_mask(input logic [MASK_W-1:0] mask);
        i_in_valid <= 1'b0;
        while (voices.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        voices.prog_mask = mask;
    endtask

    // Mostly musical traffic: note-ons from a small channel/note pool and
    // note-offs of voices that are actually sounding; the rest is noise.
    task automatic send_random_request();
        logic                 cmd;
        logic [CHANNEL_W-1:0] ch;
        logic [NOTE_W-1:0]    nt;
        int                   live[$];
        int                   pick;
        cmd = ($urandom_range(99) < 40) ? CMD_NOTE_OFF : CMD_NOTE_ON;
        ch  = ($urandom_range(99) < 75) ? chan_pool[$urandom_range(3)]
                                        : CHANNEL_W'($urandom_range(15));
        nt  = ($urandom_range(99) < 70) ? note_pool[$urandom_range(5)]
                                        : NOTE_W'($urandom_range(127));
        if (cmd == CMD_NOTE_OFF && $urandom_range(99) < 75) begin
            for (int i = 0; i < VOICES; i++) begin
                if (voices.in_use[i] && voices.sounding[i])
                    live.push_back(i);
            end
            if (live.size() > 0) begin
                pick = live[$urandom_range(live.size() - 1)];
                ch   = voices.voice_chan[pick];
                nt   = voices.voice_note[pick];
            end
        end
        send_request(cmd, ch, nt);
    endtask

    initial begin
        logic [MASK_W-1:0]    mask;
        logic [CHANNEL_W-1:0] c;
        voices = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset mask has no programs, so the first note-on is refused.
        send_request(CMD_NOTE_ON, 4'd3, 7'd60);
        write_program_mask(16'hFFFF);
        send_request(CMD_NOTE_ON,  4'd0,  7'd0);    // fresh on an empty table
        send_request(CMD_NOTE_ON,  4'd0,  7'd0);    // same channel and note again
        send_request(CMD_NOTE_OFF, 4'd0,  7'd0);    // release
        send_request(CMD_NOTE_OFF, 4'd0,  7'd0);    // nothing left to release
        send_request(CMD_NOTE_ON,  4'd0,  7'd127);  // same channel, idle voice
        send_request(CMD_NOTE_ON,  4'd15, 7'd127);
        send_request(CMD_NOTE_OFF, 4'd15, 7'd0);    // wrong note, not found
        send_request(CMD_NOTE_ON,  4'd15, 7'd127);  // retrigger a sounding note
        send_request(CMD_NOTE_OFF, 4'd0,  7'd127);
        // Drop programs on channels 0 and 15: off keeps the voice sounding.
        write_program_mask(16'h7FFE);
        send_request(CMD_NOTE_OFF, 4'd15, 7'd127);
        send_request(CMD_NOTE_ON,  4'd0,  7'd1);
        // Fill the rest of the table so later traffic has to steal.
        for (int n = 0; n < 14; n++)
            send_request(CMD_NOTE_ON, 4'd7, NOTE_W'(64 + n));

        // Random phases: mask setting and idling pattern change per phase.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 7: mask = 16'hFFFF;
                2:    mask = 16'h0001;
                4:    mask = 16'h8000;
                5:    mask = 16'h0000;
                default: begin
                    mask = MASK_W'($urandom);
                end
            endcase
            write_program_mask(mask);
            // one pooled channel always has a program when any channel does
            c = CHANNEL_W'($urandom_range(15));
            if (mask != 0) begin
                while (!mask[c])
                    c = CHANNEL_W'($urandom_range(15));
            end
            chan_pool[0] = c;
            for (int k = 1; k < 4; k++)
                chan_pool[k] = CHANNEL_W'($urandom_range(15));
            for (int k = 0; k < 6; k++)
                note_pool[k] = NOTE_W'($urandom_range(127));
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 83;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 83;
                end
                default: begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            repeat (225) send_random_request();
        end

        i_in_valid <= 1'b0;
        while (voices.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (voices.mismatch_count == 0 && voices.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/nva_pkg.sv
rtl/core/nva_ctrl.sv
rtl/core/nva_dp.sv
rtl/core/note_voice_allocator_core.sv
bench/tb_note_voice_allocator_core.sv
